/* design/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// An antecedent that, when true, requires the consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// An antecedent that, when true, requires the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/nm91_pkg.sv */
// Package with the types and constants of the mapper 91 bank and IRQ block.
`default_nettype none

package nm91_pkg;

    // Input word command codes.
    typedef enum logic [2:0] {
        CMD_WRITE    = 3'd0,
        CMD_SCANLINE = 3'd1,
        CMD_CYCLE    = 3'd2,
        CMD_PRG      = 3'd3,
        CMD_CHR      = 3'd4
    } cmd_t;

    // Field widths.
    localparam int CMD_W   = 3;
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int BANK_W  = 11;
    localparam int COUNT_W = 16;

    // Scanline IRQ fires when the line count reaches this value.
    localparam logic [3:0] LINE_LIMIT = 4'd8;
    // Amount subtracted from the cycle counter whenever the two-bit prescaler wraps.
    localparam logic [COUNT_W-1:0] CYCLE_STEP = 16'd5;

    // Result of one input word.
    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic              irq_line;
        logic              horizontal_mirroring;
    } result_t;

endpackage

`default_nettype wire

/* design/nm91_core.sv */
// Mapper state registers, write decoding, IRQ counters and bank lookup.
`default_nettype none

module nm91_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         submapper,
    input  logic [nm91_pkg::CMD_W-1:0]   cmd,
    input  logic [nm91_pkg::ADDR_W-1:0]  addr,
    input  logic [nm91_pkg::DATA_W-1:0]  val,
    output nm91_pkg::result_t            res
);
    import nm91_pkg::*;

    // Write pages selected by address bits 15..12.
    localparam logic [3:0] PAGE_CHR   = 4'h6;
    localparam logic [3:0] PAGE_PRG   = 4'h7;
    localparam logic [3:0] PAGE_OUTA  = 4'h8;
    localparam logic [3:0] PAGE_OUTB  = 4'h9;

    logic [3:0]         prg_reg [2];
    logic [3:0]         prg_next [2];
    logic [7:0]         chr_reg [4];
    logic [7:0]         chr_next [4];
    logic [7:0]         outer_reg, outer_next;
    logic               mirror_reg, mirror_next;
    logic               irq_en_reg, irq_en_next;
    logic [3:0]         line_reg, line_next;
    logic [1:0]         presc_reg, presc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               pend_reg, pend_next;
    logic [COUNT_W-1:0] count_dec;
    logic [3:0]         line_inc;
    logic [3:0]         prg_low;
    logic [BANK_W-1:0]  bank_val;

    assign count_dec = count_reg - CYCLE_STEP;
    assign line_inc  = line_reg + 4'd1;

    // Next state for the word being processed.
    always_comb
    begin
        prg_next    = prg_reg;
        chr_next    = chr_reg;
        outer_next  = outer_reg;
        mirror_next = mirror_reg;
        irq_en_next = irq_en_reg;
        line_next   = line_reg;
        presc_next  = presc_reg;
        count_next  = count_reg;
        pend_next   = pend_reg;
        if (step)
        begin
            unique case (cmd_t'(cmd))
                CMD_WRITE:
                begin
                    unique case (addr[15:12])
                        PAGE_CHR:
                        begin
                            if (submapper)
                            begin
                                unique case (addr[2:0])
                                    3'd4: mirror_next = 1'b1;
                                    3'd5: mirror_next = 1'b0;
                                    3'd6: count_next  = {count_reg[15:8], val};
                                    3'd7: count_next  = {val, count_reg[7:0]};
                                    default: chr_next[addr[1:0]] = val;
                                endcase
                            end
                            else
                            begin
                                chr_next[addr[1:0]] = val;
                            end
                        end
                        PAGE_PRG:
                        begin
                            unique case (addr[1:0])
                                2'd2:
                                begin
                                    irq_en_next = 1'b0;
                                    line_next   = 4'd0;
                                    pend_next   = 1'b0;
                                end
                                2'd3:
                                begin
                                    irq_en_next = 1'b1;
                                    presc_next  = 2'd3;
                                    pend_next   = 1'b0;
                                end
                                default: prg_next[addr[0]] = val[3:0];
                            endcase
                        end
                        PAGE_OUTA, PAGE_OUTB: outer_next = addr[7:0];
                        default: ;
                    endcase
                end
                CMD_SCANLINE:
                begin
                    // Count enabled scanlines up to the limit, then hold.
                    if (!submapper && irq_en_reg && (line_reg < LINE_LIMIT))
                    begin
                        line_next = line_inc;
                        if (line_inc >= LINE_LIMIT)
                            pend_next = 1'b1;
                    end
                end
                CMD_CYCLE:
                begin
                    // Each wrap of the two-bit prescaler drops the counter; IRQ at or below zero.
                    if (submapper)
                    begin
                        presc_next = presc_reg + 2'd1;
                        if (presc_next == 2'd0)
                        begin
                            count_next = count_dec;
                            if (((count_dec == '0) || count_dec[COUNT_W-1]) && irq_en_reg)
                                pend_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Bank lookup from the current registers.
    always_comb
    begin
        unique case (addr[14:13])
            2'd0: prg_low = prg_reg[0];
            2'd1: prg_low = prg_reg[1];
            2'd2: prg_low = 4'hE;
            default: prg_low = 4'hF;
        endcase
        unique case (cmd_t'(cmd))
            CMD_PRG:
                bank_val = addr[15] ? {outer_reg[7:1], prg_low} : '0;
            CMD_CHR:
                bank_val = (addr[15:13] == 3'd0) ?
                           {2'b00, outer_reg[0], chr_reg[addr[12:11]]} : '0;
            default: bank_val = '0;
        endcase
    end

    // The IRQ line and mirroring reflect the state after this word; the bank uses the state before it.
    assign res.bank                 = bank_val;
    assign res.irq_line             = pend_next;
    assign res.horizontal_mirroring = submapper & mirror_next;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_reg    <= '{default: '0};
            chr_reg    <= '{default: '0};
            outer_reg  <= '0;
            mirror_reg <= 1'b0;
            irq_en_reg <= 1'b0;
            line_reg   <= '0;
            presc_reg  <= '0;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            prg_reg    <= prg_next;
            chr_reg    <= chr_next;
            outer_reg  <= outer_next;
            mirror_reg <= mirror_next;
            irq_en_reg <= irq_en_next;
            line_reg   <= line_next;
            presc_reg  <= presc_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

`default_nettype wire

/* design/nes_mapper91_bank_irq_core.sv */
// Mapper 91 bank lookup and IRQ block: top level.
//
// Usage: each input word on (command, address, value) is a CPU write, a
// scanline-end tick, a CPU-cycle tick, or a PRG or CHR bank lookup. It is
// taken at a rising edge where in_valid is high and in_stall is low. Every
// word yields exactly one output word (bank, irq_line, horizontal_mirroring),
// taken at an edge where out_valid is high and out_stall is low.
// A word taken at an edge is held in the input register, then processed
// into the output register, from which it can be taken. Throughput is one
// word per cycle while out_stall is low; the input and output registers
// form a two-entry pipeline, so a new word is taken while a result still
// waits. When the receiver stalls, the output word holds and in_stall rises
// only once both registers are full. The submapper register is written
// through cfg_valid/cfg_ready (always ready); the user must write it only
// while the block is idle, which the block does not enforce. Reset clears
// all mapper state, selects submapper 0 and empties the pipeline.
`default_nettype none

module nes_mapper91_bank_irq_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_submapper,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [nm91_pkg::CMD_W-1:0]   command,
    input  logic [nm91_pkg::ADDR_W-1:0]  address,
    input  logic [nm91_pkg::DATA_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [nm91_pkg::BANK_W-1:0]  bank,
    output logic                         irq_line,
    output logic                         horizontal_mirroring
);
    import nm91_pkg::*;

    logic              sub_reg;
    logic              s1_valid_reg;
    logic [CMD_W-1:0]  s1_cmd_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [DATA_W-1:0] s1_val_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    result_t           res;
    logic              advance;
    logic              step;

    // The output register can take a new word when empty or being drained.
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign step      = s1_valid_reg && advance;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sub_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            sub_reg <= cfg_submapper;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_cmd_reg  <= command;
            s1_addr_reg <= address;
            s1_val_reg  <= value;
        end
    end

    nm91_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .submapper (sub_reg),
        .cmd       (s1_cmd_reg),
        .addr      (s1_addr_reg),
        .val       (s1_val_reg),
        .res       (res)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_res_reg <= res;
    end

    assign out_valid            = out_valid_reg;
    assign bank                 = out_res_reg.bank;
    assign irq_line             = out_res_reg.irq_line;
    assign horizontal_mirroring = out_res_reg.horizontal_mirroring;

endmodule

`default_nettype wire

/* design/nm91_checker.sv */
// Port-level checker for the mapper 91 block and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module nm91_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic                         cfg_submapper,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [nm91_pkg::BANK_W-1:0]  bank,
    input  logic                         irq_line,
    input  logic                         horizontal_mirroring
);
    import nm91_pkg::*;

    logic       sub_shadow_reg;
    logic [1:0] occ_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;

    // Shadow of the submapper register and count of words in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_shadow_reg <= 1'b0;
            occ_reg        <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                sub_shadow_reg <= cfg_submapper;
            occ_reg <= occ_reg + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    // A stalled output word stays valid and holds its payload.
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output word dropped while stalled")
    `ASSERT_NEXT(a_out_stable, out_valid && out_stall,
                 $stable(bank) && $stable(irq_line) && $stable(horizontal_mirroring),
                 "stalled output payload changed")

    // No result appears without an accepted word, and at most two are in flight.
    `ASSERT_IMPL(a_no_invent, occ_reg == 2'd0, !out_valid, "output word without an accepted input word")
    `ASSERT_ALWAYS(a_occupancy, occ_reg != 2'd3, "more than two words in flight")

    // Mirroring control only exists in submapper 1.
    `ASSERT_IMPL(a_mirror_sub0, out_valid && !sub_shadow_reg, !horizontal_mirroring, "mirroring reported in submapper 0")

endmodule

bind nes_mapper91_bank_irq_core nm91_checker u_nm91_checker (.*);

`default_nettype wire
